// File: sv/oaat_pkg.sv
package oaat_pkg;

  localparam int HASH_W = 64;
  localparam int CHAR_W = 8;
  localparam int BKT_W  = 21;
  localparam int IDX_W  = 20;
  localparam int CNT_W  = $clog2(HASH_W);

  localparam logic [BKT_W-1:0] BUCKET_LIMIT = BKT_W'(1048576);
  localparam logic [BKT_W-1:0] BUCKET_RESET = BKT_W'(10000);

  // Shift amounts of the mixing and finishing rounds
  localparam int SHL_MIX  = 10;
  localparam int SHR_MIX  = 6;
  localparam int SHL_FIN1 = 3;
  localparam int SHR_FIN1 = 11;
  localparam int SHL_FIN2 = 15;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ADD_CHAR,
    OP_MIX,
    OP_FIN1,
    OP_FIN2,
    OP_CLEAR
  } mix_op_t;

  typedef struct packed {
    mix_op_t                  op;
    logic [CHAR_W-1:0]        char_code;
  } mix_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DRAIN
  } state_t;

endpackage

// File: sv/one_at_a_time_string_hash.sv
// Sequence: each character is accepted, then mixed on the shared 64-bit adder; the
// last character adds two finishing rounds, a divider start, 64 remainder steps,
// a done step and a load into the output register, which raises out_tvalid.
// A new character is not taken while the one before is being mixed; a last
// character keeps in_tready low until its result is loaded, and the load waits while an earlier result is stalled.
// Reset (rst_n, synchronous, low): hash cleared, bucket count back to 10000.
module one_at_a_time_string_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] bucket_index, [23:20] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data    // bucket_count
);

  oaat_pkg::state_t              state_r;
  oaat_pkg::state_t              state_nxt;
  oaat_pkg::mix_ctl_t            mix_ctl;
  logic                          last_r;
  logic [oaat_pkg::BKT_W-1:0]    bucket_r;
  logic [oaat_pkg::BKT_W-1:0]    divisor;
  logic [oaat_pkg::HASH_W-1:0]   hash;
  logic                          div_start;
  logic                          div_done;
  logic [oaat_pkg::IDX_W-1:0]    div_rem;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [oaat_pkg::IDX_W-1:0]    out_idx_r;
  logic                          out_load;

  oaat_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mix_ctl),
    .hash  (hash)
  );

  // Clamp the bucket count so the remainder fits 20 bits
  assign divisor = (bucket_r > oaat_pkg::BUCKET_LIMIT) ? oaat_pkg::BUCKET_LIMIT : bucket_r;

  oaat_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (hash),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r <= oaat_pkg::BUCKET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bucket_r <= cfg_data;
    end
  end

  // Sequencer: next state and controls
  always_comb begin
    state_nxt         = state_r;
    in_tready         = 1'b0;
    mix_ctl.op        = oaat_pkg::OP_HOLD;
    mix_ctl.char_code = in_tdata;
    div_start         = 1'b0;
    out_load          = 1'b0;
    unique case (state_r)
      oaat_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mix_ctl.op = oaat_pkg::OP_ADD_CHAR;
          state_nxt  = oaat_pkg::ST_MIX;
        end
      end
      oaat_pkg::ST_MIX: begin
        mix_ctl.op = oaat_pkg::OP_MIX;
        state_nxt  = last_r ? oaat_pkg::ST_FIN1 : oaat_pkg::ST_IDLE;
      end
      oaat_pkg::ST_FIN1: begin
        mix_ctl.op = oaat_pkg::OP_FIN1;
        state_nxt  = oaat_pkg::ST_FIN2;
      end
      oaat_pkg::ST_FIN2: begin
        mix_ctl.op = oaat_pkg::OP_FIN2;
        state_nxt  = oaat_pkg::ST_DIV_START;
      end
      oaat_pkg::ST_DIV_START: begin
        // Divider captures the finished hash while the hash clears
        div_start  = 1'b1;
        mix_ctl.op = oaat_pkg::OP_CLEAR;
        state_nxt  = oaat_pkg::ST_DIV_RUN;
      end
      oaat_pkg::ST_DIV_RUN: begin
        if (div_done) begin
          state_nxt = oaat_pkg::ST_DRAIN;
        end
      end
      oaat_pkg::ST_DRAIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = oaat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = oaat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oaat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the last flag of the accepted transaction
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      last_r <= in_tlast;
    end
  end

  // Output register: hold until taken, reload when free
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r <= div_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_idx_r};

endmodule

// File: sv/oaat_mix.sv
module oaat_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  oaat_pkg::mix_ctl_t            ctl,
  output logic [oaat_pkg::HASH_W-1:0]   hash
);

  logic [oaat_pkg::HASH_W-1:0] hash_r;
  logic [oaat_pkg::HASH_W-1:0] hash_nxt;
  logic [oaat_pkg::HASH_W-1:0] add_b;
  logic [oaat_pkg::HASH_W-1:0] sum;

  // Pick the second adder operand for this step
  always_comb begin
    unique case (ctl.op)
      oaat_pkg::OP_ADD_CHAR:
        add_b = {{(oaat_pkg::HASH_W-oaat_pkg::CHAR_W){ctl.char_code[oaat_pkg::CHAR_W-1]}},
                 ctl.char_code};
      oaat_pkg::OP_MIX:  add_b = hash_r << oaat_pkg::SHL_MIX;
      oaat_pkg::OP_FIN1: add_b = hash_r << oaat_pkg::SHL_FIN1;
      oaat_pkg::OP_FIN2: add_b = hash_r << oaat_pkg::SHL_FIN2;
      default:           add_b = '0;
    endcase
  end

  assign sum = hash_r + add_b;

  // Fold in the right-shift xor where the round has one
  always_comb begin
    unique case (ctl.op)
      oaat_pkg::OP_ADD_CHAR: hash_nxt = sum;
      oaat_pkg::OP_MIX:      hash_nxt = sum ^ (sum >> oaat_pkg::SHR_MIX);
      oaat_pkg::OP_FIN1:     hash_nxt = sum ^ (sum >> oaat_pkg::SHR_FIN1);
      oaat_pkg::OP_FIN2:     hash_nxt = sum;
      oaat_pkg::OP_CLEAR:    hash_nxt = '0;
      default:               hash_nxt = hash_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

// File: sv/oaat_mod.sv
module oaat_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [oaat_pkg::HASH_W-1:0]   dividend,
  input  logic [oaat_pkg::BKT_W-1:0]    divisor,
  output logic                          done,
  output logic [oaat_pkg::IDX_W-1:0]    remainder
);

  logic                          busy_r;
  logic                          done_r;
  logic [oaat_pkg::CNT_W-1:0]    cnt_r;
  logic [oaat_pkg::HASH_W-1:0]   dvd_r;
  logic [oaat_pkg::IDX_W-1:0]    rem_r;
  logic [oaat_pkg::BKT_W-1:0]    div_r;
  logic [oaat_pkg::BKT_W-1:0]    rem_sh;
  logic [oaat_pkg::BKT_W-1:0]    rem_sub;
  logic [oaat_pkg::IDX_W-1:0]    rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, dvd_r[oaat_pkg::HASH_W-1]};
    rem_sub = rem_sh - div_r;
    rem_nxt = (rem_sh >= div_r) ? rem_sub[oaat_pkg::IDX_W-1:0]
                                : rem_sh[oaat_pkg::IDX_W-1:0];
  end

  // Sequence one bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == oaat_pkg::CNT_W'(oaat_pkg::HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  // A zero bucket count maps every word to bucket zero
  assign remainder = (div_r == '0) ? '0 : rem_r;

endmodule

// File: sv/oaat_checker.sv
module oaat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [20:0] cfg_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Bucket index stays below 2^20
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'b0)
    else $error("bucket index out of range");

  // Each character keeps the shared adder busy for its mix step, so the input closes after a take
  a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");

  // A new result only comes from the load cycle, when input is closed
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a finished word");

  // The configuration channel never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration channel stalled");

endmodule

bind one_at_a_time_string_hash oaat_checker u_oaat_checker (.*);
